// File: rtl/psdl_pkg.sv
// Package for the plucked-string delay loop: widths, function and op codes,
// register indexes, state encodings and the queue entry type.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package psdl_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int SAMPLE_W        = 16;
    localparam int FUNC_W          = 2;
    localparam int TABLE_LENGTH_W  = 11;
    localparam int GAIN_W          = 16;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 16;
    localparam int PROD_W          = SAMPLE_W + 1 + GAIN_W + 1;
    localparam int QUOT_W          = PROD_W - 16;

    localparam logic [GAIN_W-1:0] GAIN_ONE        = 16'd32768;
    localparam logic [TABLE_LENGTH_W-1:0] LEN_RST = 11'd100;

    localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_GEN   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOOP_GAIN    = 1'd1;

    typedef enum logic [1:0] {
        OP_START,
        OP_LOAD,
        OP_GEN
    } op_t;

    typedef enum logic {
        BK_ISSUE,
        BK_CALC
    } back_state_t;

    typedef struct packed {
        op_t                 op;
        logic [SAMPLE_W-1:0] data;
    } q_entry_t;

endpackage

`default_nettype wire

// File: rtl/psdl_front.sv
// Front end: accepts input requests, keeps the play and load positions and
// turns each request into a queue entry with its table address. Uses psdl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psdl_front
    import psdl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [FUNC_W-1:0]         func,
    input  wire logic [SAMPLE_W-1:0]       excitation,
    input  wire logic [TABLE_LENGTH_W-1:0] table_length,
    input  wire logic                      q_full,
    output logic                           push,
    output q_entry_t                       push_entry,
    output logic [AW-1:0]                  push_addr
);

    localparam int LW = (AW + 1 > TABLE_LENGTH_W) ? AW + 1 : TABLE_LENGTH_W;

    logic [AW-1:0] play_pos_reg, play_pos_next;
    logic [AW-1:0] load_pos_reg, load_pos_next;
    logic [LW-1:0] len_ext, eff_len;
    logic [LW-1:0] play_idx, load_idx, play_inc, load_inc;
    logic          accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign len_ext  = LW'(table_length);

    // Length zero acts as one, and a length past the table acts as the table depth.
    always_comb begin
        if (len_ext == '0) begin
            eff_len = LW'(1);
        end else if (len_ext > LW'(TABLE_DEPTH)) begin
            eff_len = LW'(TABLE_DEPTH);
        end else begin
            eff_len = len_ext;
        end
    end

    // A position left past a shortened length wraps to zero before use.
    always_comb begin
        play_idx = (LW'(play_pos_reg) >= eff_len) ? '0 : LW'(play_pos_reg);
        load_idx = (LW'(load_pos_reg) >= eff_len) ? '0 : LW'(load_pos_reg);
        play_inc = play_idx + LW'(1);
        load_inc = load_idx + LW'(1);
    end

    always_comb begin
        play_pos_next   = play_pos_reg;
        load_pos_next   = load_pos_reg;
        push            = 1'b0;
        push_entry.op   = OP_START;
        push_entry.data = excitation;
        push_addr       = '0;
        if (accept) begin
            case (func)
                FUNC_START: begin
                    play_pos_next = '0;
                    load_pos_next = '0;
                    push          = 1'b1;
                end
                FUNC_LOAD: begin
                    push_entry.op = OP_LOAD;
                    push_addr     = load_idx[AW-1:0];
                    load_pos_next = (load_inc >= eff_len) ? '0 : load_inc[AW-1:0];
                    push          = 1'b1;
                end
                FUNC_GEN: begin
                    push_entry.op = OP_GEN;
                    push_addr     = play_idx[AW-1:0];
                    play_pos_next = (play_inc >= eff_len) ? '0 : play_inc[AW-1:0];
                    push          = 1'b1;
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            play_pos_reg <= '0;
            load_pos_reg <= '0;
        end else begin
            play_pos_reg <= play_pos_next;
            load_pos_reg <= load_pos_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/psdl_queue.sv
// Two-entry queue between the front end and the back end of the delay loop.
// Generic payload width; uses psdl_pkg only for the common import style.
`timescale 1ns / 1ps
`default_nettype none

module psdl_queue
    import psdl_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      pop_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/psdl_back.sv
// Back end: owns the delay table memory and the previous output, runs the
// loop filter for generate entries and holds the output register. Uses psdl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psdl_back
    import psdl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    input  wire q_entry_t            q_entry,
    input  wire logic [AW-1:0]       q_addr,
    output logic                     q_pop,
    input  wire logic [GAIN_W-1:0]   loop_gain,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [SAMPLE_W-1:0]      m_tdata
);

    logic [SAMPLE_W-1:0] table_mem [TABLE_DEPTH];

    back_state_t                state_reg, state_next;
    logic [AW-1:0]              addr_hold_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic signed [SAMPLE_W-1:0] last_output_reg;
    logic                       m_valid_reg;
    logic [SAMPLE_W-1:0]        m_data_reg;

    logic                       out_free;
    logic                       rd_en, mem_we, last_clear, y_load;
    logic [AW-1:0]              mem_waddr;
    logic [SAMPLE_W-1:0]        mem_wdata;
    logic [GAIN_W-1:0]          gain_c;
    logic signed [SAMPLE_W:0]   sum;
    logic signed [PROD_W-1:0]   prod;
    logic signed [QUOT_W-1:0]   quot;
    logic signed [SAMPLE_W-1:0] y;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Loop filter: floor(gain * (entry + previous) / 65536), then saturate.
    always_comb begin
        gain_c = (loop_gain > GAIN_ONE) ? GAIN_ONE : loop_gain;
        sum    = (SAMPLE_W + 1)'(rd_data_reg) + (SAMPLE_W + 1)'(last_output_reg);
        prod   = PROD_W'(sum) * $signed(PROD_W'({1'b0, gain_c}));
        quot   = prod[PROD_W-1:16];
        if (quot > QUOT_W'(32767)) begin
            y = 16'sh7FFF;
        end else if (quot < -QUOT_W'(32768)) begin
            y = 16'sh8000;
        end else begin
            y = quot[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_ISSUE: begin
                if (q_valid && q_entry.op == OP_GEN) begin
                    state_next = BK_CALC;
                end
            end
            BK_CALC: begin
                if (out_free) begin
                    state_next = BK_ISSUE;
                end
            end
            default: begin
                state_next = BK_ISSUE;
            end
        endcase
    end

    always_comb begin
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = q_addr;
        mem_wdata  = q_entry.data;
        last_clear = 1'b0;
        y_load     = 1'b0;
        case (state_reg)
            BK_ISSUE: begin
                q_pop = q_valid;
                if (q_valid) begin
                    case (q_entry.op)
                        OP_START: last_clear = 1'b1;
                        OP_LOAD:  mem_we     = 1'b1;
                        OP_GEN:   rd_en      = 1'b1;
                        default:  last_clear = 1'b0;
                    endcase
                end
            end
            BK_CALC: begin
                if (out_free) begin
                    y_load    = 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = addr_hold_reg;
                    mem_wdata = y;
                end
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg   <= table_mem[q_addr];
            addr_hold_reg <= q_addr;
        end
        if (y_load) begin
            m_data_reg <= y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= BK_ISSUE;
            last_output_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (last_clear) begin
                last_output_reg <= '0;
            end else if (y_load) begin
                last_output_reg <= y;
            end
            if (y_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/plucked_string_delay_loop_top.sv
// Top level of the plucked-string delay loop: configuration registers and the
// front end, queue and back end. Depends on psdl_pkg and the three psdl modules.
//
// Use: each input request carries a function code in s_tuser (start note,
// load excitation sample, generate sample; code 3 is ignored) and an
// excitation sample in s_tdata. Start clears the play and load positions and
// the previous output, load writes the next excitation sample into the
// circular delay table, and generate emits one synthesized sample on m_tdata.
// Only generate requests produce an output request.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) set the table length and
// the loop gain; they are taken in any cycle but are meant for an idle block.
// A generate request taken into an empty block is written into the queue at the
// accepting edge; its table read is then registered, and the filter result is
// registered into the output register that drives m_tvalid and m_tdata.
// The back end handles a generate as a registered table read and then the filter
// and write-back on the single write port, and takes no new queue entry until
// that write-back; a start or a load is handled as its entry is popped. The front
// end accepts one request per cycle while the two-entry queue has room.
// Reset (aresetn low, synchronous) empties the queue, clears the positions,
// previous output and output valid, and restores length 100 and gain 1.0.
// The table contents are not cleared. When the receiver stalls, the finished
// sample waits in the output register, the back end holds its next generate,
// and s_tready drops once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module plucked_string_delay_loop_top
    import psdl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Input channel.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [SAMPLE_W-1:0]    s_tdata,   // [15:0] excitation
    input  wire logic [FUNC_W-1:0]      s_tuser,   // [1:0] func
    // Result channel.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [SAMPLE_W-1:0]         m_tdata,   // [15:0] audio_out
    // Configuration write port.
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int QE_W = $bits(q_entry_t) + AW;

    logic [TABLE_LENGTH_W-1:0] table_length_reg;
    logic [GAIN_W-1:0]         loop_gain_reg;

    logic            push, q_full, q_valid, q_pop;
    q_entry_t        push_entry, pop_entry;
    logic [AW-1:0]   push_addr, pop_addr;
    logic [QE_W-1:0] pop_word;

    // Configuration registers; an index outside the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_length_reg <= LEN_RST;
            loop_gain_reg    <= GAIN_ONE;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TABLE_LENGTH: table_length_reg <= cfg_wdata[TABLE_LENGTH_W-1:0];
                REG_LOOP_GAIN:    loop_gain_reg    <= cfg_wdata[GAIN_W-1:0];
                default:          loop_gain_reg    <= loop_gain_reg;
            endcase
        end
    end

    psdl_front #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .AW         (AW)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .func        (s_tuser),
        .excitation  (s_tdata),
        .table_length(table_length_reg),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry),
        .push_addr   (push_addr)
    );

    psdl_queue #(
        .WIDTH(QE_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data({push_addr, push_entry}),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_valid),
        .pop_data (pop_word)
    );

    assign pop_entry = pop_word[$bits(q_entry_t)-1:0];
    assign pop_addr  = pop_word[QE_W-1:$bits(q_entry_t)];

    psdl_back #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .AW         (AW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (pop_entry),
        .q_addr   (pop_addr),
        .q_pop    (q_pop),
        .loop_gain(loop_gain_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// File: rtl/psdl_checker.sv
// Port-level checker for the plucked-string delay loop, bound to the top level.
// Depends on psdl_pkg and plucked_string_delay_loop_top.
`timescale 1ns / 1ps
`default_nettype none

module psdl_checker
    import psdl_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [SAMPLE_W-1:0] m_tdata
);

    // Reset drops any pending output sample.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // Reset empties the queue, so the input side is ready right after it.
    assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // A fresh block cannot show a sample straight after leaving reset.
    assert property (@(posedge aclk) $past(!aresetn) && aresetn |=> !m_tvalid)
        else $error("output appeared too soon after reset");

    // A stalled output sample holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output changed");

endmodule

bind plucked_string_delay_loop_top psdl_checker u_psdl_checker (.*);

`default_nettype wire
